[src/mpe_pkg.sv]
// mpe_pkg: types, constants and sequencer states for modular polynomial evaluation
// used by modular_polynomial_evaluation_top and mpe_checker, depends on nothing

package mpe_pkg;

   localparam int COEF_WIDTH     = 32;
   localparam int VAL_WIDTH      = 31;
   localparam int MPL_WIDTH      = (COEF_WIDTH > VAL_WIDTH) ? COEF_WIDTH : VAL_WIDTH;
   localparam int CNT_WIDTH      = $clog2(MPL_WIDTH);
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [VAL_WIDTH-1:0] MODULUS_RESET = VAL_WIDTH'(1000000007);
   localparam logic [VAL_WIDTH-1:0] POINT_RESET   = VAL_WIDTH'(2);

   // register index, taken from address bit 2
   localparam logic REG_MODULUS = 1'b0;
   localparam logic REG_POINT   = 1'b1;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] coefficient;
      logic                         last_coeff;
   } req_type;

   typedef struct packed {
      logic [VAL_WIDTH-1:0] residue;
      logic                 is_zero;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RED_POW,
      ST_RED_RES,
      ST_MUL_COEF,
      ST_MUL_POW,
      ST_DONE
   } state_type;

endpackage

[src/modular_polynomial_evaluation_top.sv]
// modular_polynomial_evaluation_top: residue of a streamed polynomial at a point
// uses mpe_pkg for item types, register constants and sequencer states
//
// req channel: one coefficient per item, lowest degree first, last_coeff on the
// highest-degree term. rsp channel: one item per polynomial, the residue in
// 0..modulus-1 and a zero flag. csr port: modulus at 0x0, eval_point at 0x4.
// all modular products run on one shift-add-reduce unit, one multiplier bit a
// cycle. a coefficient takes two operations after it is accepted, or four when
// modulus has been rewritten since the previous coefficient (stored residue
// and power are reduced again first). the item marked last then passes
// through ST_DONE, which loads the output register.
// req_stall is high from accept until the item is finished. the result waits
// in the output register while rsp_stall is high; the next coefficient is
// still taken, and only the next last item waits for the register to empty.
// synchronous reset: modulus 1000000007, eval_point 2, new polynomial, no result
// pending. the user must write configuration only between items (not enforced).

module modular_polynomial_evaluation_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mpe_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mpe_pkg::rsp_type                   rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mpe_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [mpe_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [mpe_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready
);
   import mpe_pkg::*;

   localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(MPL_WIDTH - 1);
   localparam logic [VAL_WIDTH-1:0] ONE       = VAL_WIDTH'(1);

   state_type               state_ff, state_in;
   logic [VAL_WIDTH-1:0]    modulus_ff, modulus_in;
   logic [VAL_WIDTH-1:0]    point_ff, point_in;
   logic [VAL_WIDTH-1:0]    res_ff, res_in;
   logic [VAL_WIDTH-1:0]    pow_ff, pow_in;
   logic                    first_ff, first_in;
   logic                    stale_ff, stale_in;
   logic [COEF_WIDTH-1:0]   mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic                    last_ff, last_in;
   logic [MPL_WIDTH-1:0]    mplier_ff, mplier_in;
   logic [VAL_WIDTH-1:0]    mcand_ff, mcand_in;
   logic [VAL_WIDTH-1:0]    acc_ff, acc_in;
   logic [CNT_WIDTH-1:0]    cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic                    csr_write;
   logic                    step_done;
   logic                    rsp_free;
   logic [VAL_WIDTH-1:0]    m_eff;
   logic [COEF_WIDTH-1:0]   req_mag;
   logic [VAL_WIDTH+1:0]    sum_w, m1_w, m2_w, diff1_w, diff2_w;
   logic [VAL_WIDTH-1:0]    step_acc;
   logic [VAL_WIDTH-1:0]    fold_base;
   logic [VAL_WIDTH:0]      fold_add, fold_sub, fold_add_red, fold_sub_fix;
   logic [VAL_WIDTH-1:0]    fold_res;

   assign accept     = req_valid && !req_stall;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign step_done  = (cnt_ff == LAST_STEP);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign m_eff      = (modulus_ff < VAL_WIDTH'(2)) ? ONE : modulus_ff;
   assign req_mag    = req_data.coefficient[COEF_WIDTH-1]
                       ? (~req_data.coefficient + COEF_WIDTH'(1))
                       : req_data.coefficient;

   always_comb begin
      case (csr_paddr[2])
         REG_MODULUS: csr_prdata = CSR_DATA_WIDTH'(modulus_ff);
         REG_POINT:   csr_prdata = CSR_DATA_WIDTH'(point_ff);
         default:     csr_prdata = '0;
      endcase
   end

   // shared unit: acc = (2*acc + bit*mcand) mod m, acc and mcand below m
   assign sum_w   = {1'b0, acc_ff, 1'b0}
                    + (mplier_ff[MPL_WIDTH-1] ? {2'b00, mcand_ff} : '0);
   assign m1_w    = {2'b00, m_eff};
   assign m2_w    = {1'b0, m_eff, 1'b0};
   assign diff1_w = sum_w - m1_w;
   assign diff2_w = sum_w - m2_w;

   always_comb begin
      if (sum_w >= m2_w) begin
         step_acc = diff2_w[VAL_WIDTH-1:0];
      end else if (sum_w >= m1_w) begin
         step_acc = diff1_w[VAL_WIDTH-1:0];
      end else begin
         step_acc = sum_w[VAL_WIDTH-1:0];
      end
   end

   // residue plus or minus the product just finished
   assign fold_base    = first_ff ? '0 : res_ff;
   assign fold_add     = {1'b0, fold_base} + {1'b0, step_acc};
   assign fold_sub     = {1'b0, fold_base} - {1'b0, step_acc};
   assign fold_add_red = (fold_add >= {1'b0, m_eff}) ? (fold_add - {1'b0, m_eff}) : fold_add;
   assign fold_sub_fix = fold_sub[VAL_WIDTH] ? (fold_sub + {1'b0, m_eff}) : fold_sub;
   assign fold_res     = neg_ff ? fold_sub_fix[VAL_WIDTH-1:0] : fold_add_red[VAL_WIDTH-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (!first_ff && stale_ff) ? ST_RED_POW : ST_MUL_COEF;
            end
         end
         ST_RED_POW: begin
            if (step_done) state_in = ST_RED_RES;
         end
         ST_RED_RES: begin
            if (step_done) state_in = ST_MUL_COEF;
         end
         ST_MUL_COEF: begin
            if (step_done) state_in = ST_MUL_POW;
         end
         ST_MUL_POW: begin
            if (step_done) state_in = last_ff ? ST_DONE : ST_IDLE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      modulus_in   = modulus_ff;
      point_in     = point_ff;
      res_in       = res_ff;
      pow_in       = pow_ff;
      first_in     = first_ff;
      stale_in     = stale_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      last_in      = last_ff;
      mplier_in    = mplier_ff << 1;
      mcand_in     = mcand_ff;
      acc_in       = step_acc;
      cnt_in       = cnt_ff + CNT_WIDTH'(1);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            acc_in = '0;
            cnt_in = '0;
            if (accept) begin
               mag_in   = req_mag;
               neg_in   = req_data.coefficient[COEF_WIDTH-1];
               last_in  = req_data.last_coeff;
               stale_in = 1'b0;
               if (!first_ff && stale_ff) begin
                  mplier_in = MPL_WIDTH'(pow_ff);
                  mcand_in  = ONE;
               end else begin
                  mplier_in = MPL_WIDTH'(req_mag);
                  mcand_in  = first_ff ? ONE : pow_ff;
               end
            end
         end
         ST_RED_POW: begin
            if (step_done) begin
               pow_in    = step_acc;
               acc_in    = '0;
               mplier_in = MPL_WIDTH'(res_ff);
               mcand_in  = ONE;
            end
         end
         ST_RED_RES: begin
            if (step_done) begin
               res_in    = step_acc;
               acc_in    = '0;
               mplier_in = MPL_WIDTH'(mag_ff);
               mcand_in  = pow_ff;
            end
         end
         ST_MUL_COEF: begin
            if (step_done) begin
               res_in    = fold_res;
               acc_in    = '0;
               mplier_in = MPL_WIDTH'(point_ff);
               mcand_in  = first_ff ? ONE : pow_ff;
            end
         end
         ST_MUL_POW: begin
            if (step_done) begin
               pow_in   = step_acc;
               first_in = last_ff;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.residue = res_ff;
               rsp_data_in.is_zero = (res_ff == '0);
            end
         end
         default: begin
            acc_in = '0;
         end
      endcase

      if (csr_write) begin
         case (csr_paddr[2])
            REG_MODULUS: begin
               modulus_in = csr_pwdata[VAL_WIDTH-1:0];
               stale_in   = 1'b1;
            end
            REG_POINT:   point_in = csr_pwdata[VAL_WIDTH-1:0];
            default:     point_in = point_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         modulus_ff   <= MODULUS_RESET;
         point_ff     <= POINT_RESET;
         first_ff     <= 1'b1;
         stale_ff     <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         point_ff     <= point_in;
         first_ff     <= first_in;
         stale_ff     <= stale_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      pow_ff      <= pow_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      last_ff     <= last_in;
      mplier_ff   <= mplier_in;
      mcand_ff    <= mcand_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[src/mpe_checker.sv]
// mpe_checker: port-level checks on modular_polynomial_evaluation_top, bound to it
// uses mpe_pkg for the item types

module mpe_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mpe_pkg::rsp_type rsp_data,
   input logic             csr_pready
);
   import mpe_pkg::*;

   // an accepted item keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("mpe: input taken on consecutive cycles");

   // zero flag agrees with the residue
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_zero == (rsp_data.residue == '0)))
      else $error("mpe: zero flag disagrees with residue");

   // a stalled result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("mpe: stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("mpe: register port not ready");

endmodule

bind modular_polynomial_evaluation_top mpe_checker u_mpe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_data   (rsp_data),
   .csr_pready (csr_pready)
);
